/* rtl/rrg_pkg.sv */
`default_nettype none

package rrg_pkg;

    // Request from the sequencer to the shared divider
    typedef struct packed {
        logic start;   // load operands and begin a division
    } t_div_ctl;

    // Status back from the shared divider
    typedef struct packed {
        logic busy;    // division in progress
        logic done;    // quotient and remainder valid this cycle
    } t_div_sts;

endpackage

`default_nettype wire

/* rtl/rrg_divider.sv */
`default_nettype none

// Restoring divider: one compare and subtract per cycle.
module rrg_divider #(
    parameter int W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rrg_pkg::t_div_ctl i_ctl,
    input  wire logic [W-1:0]      i_dividend,
    input  wire logic [W-1:0]      i_divisor,
    output rrg_pkg::t_div_sts      o_sts,
    output logic      [W-1:0]      o_quotient,
    output logic      [W-1:0]      o_remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [W:0]    w_trial;
    logic          w_fits;
    logic [W:0]    w_diff;

    // Bring down the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_quo <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
                r_cnt <= CW'(W);
            end else if (r_cnt != '0) begin
                r_quo <= {r_quo[W-2:0], w_fits};
                r_rem <= w_fits ? w_diff[W-1:0] : w_trial[W-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy  = (r_cnt != '0);
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

/* rtl/reduce_ratio_by_gcd.sv */
`default_nettype none

// Channel  Dir  tdata fields (lowest bit up)                      tuser
// -------  ---  ------------------------------------------------  ---------
// s        in   width, height                                     -
// m        out  reduced_width, reduced_height, common_divisor     undefined
//
// Each word runs Euclid remainder steps, then divides width and height by the
// divisor; each step issues a division to the one restoring divider and waits
// for it, and both final divisions run on the same divider.
// Both inputs zero skips the divider and goes from the Euclid state straight
// to the done state.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// The input side is ready only while idle; a finished result waits in the
// output register, and the next word may be taken while it waits. A result
// that finds the output register still full holds in the done state.
module reduce_ratio_by_gcd #(
    parameter int DIM_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // width, height
    input  wire logic [((2*DIM_BITS+7)/8)*8-1:0]      i_s_tdata,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // reduced_width, reduced_height, common_divisor
    output logic      [((3*DIM_BITS+7)/8)*8-1:0]      o_m_tdata,
    // undefined
    output logic                                      o_m_tuser
);

    localparam int W     = DIM_BITS;
    localparam int OUT_W = ((3*DIM_BITS+7)/8)*8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EUCLID,
        S_MOD,
        S_DIVW,
        S_DIVH,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [W-1:0]  r_w;
    logic [W-1:0]  r_h;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;     // holds the divisor once Euclid ends
    logic [W-1:0]  r_qw;
    logic [W-1:0]  r_qh;
    logic          r_undef;
    logic          r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic          r_out_user;

    rrg_pkg::t_div_ctl w_ctl;
    rrg_pkg::t_div_sts w_sts;
    logic [W-1:0]  w_dividend;
    logic [W-1:0]  w_divisor;
    logic [W-1:0]  w_quo;
    logic [W-1:0]  w_rem;
    logic          w_x_zero;
    logic          w_s_acc;
    logic          w_m_acc;

    assign w_x_zero = (r_x == '0);
    assign w_s_acc  = i_s_tvalid && o_s_tready;
    assign w_m_acc  = r_out_valid && i_m_tready;

    // Pick operands for the shared divider: y mod x during Euclid,
    // then width / g and height / g
    always_comb begin
        w_ctl.start = 1'b0;
        w_dividend  = r_h;
        w_divisor   = r_y;
        case (r_state)
            S_EUCLID: begin
                if (!w_x_zero) begin
                    w_dividend  = r_y;
                    w_divisor   = r_x;
                    w_ctl.start = 1'b1;
                end else begin
                    w_dividend  = r_w;
                    w_divisor   = r_y;
                    w_ctl.start = (r_y != '0);
                end
            end
            S_DIVW: begin
                w_ctl.start = w_sts.done;
            end
            default: begin
                w_ctl.start = 1'b0;
            end
        endcase
    end

    rrg_divider #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_sts       (w_sts),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, else drop valid once the word leaves
            if ((r_state == S_DONE) && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (w_m_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_w     <= i_s_tdata[W-1:0];
                        r_h     <= i_s_tdata[2*W-1:W];
                        r_x     <= i_s_tdata[W-1:0];
                        r_y     <= i_s_tdata[2*W-1:W];
                        r_undef <= 1'b0;
                        r_state <= S_EUCLID;
                    end
                end
                S_EUCLID: begin
                    if (!w_x_zero) begin
                        r_state <= S_MOD;
                    end else if (r_y != '0) begin
                        r_state <= S_DIVW;
                    end else begin
                        // both inputs zero: ratio undefined
                        r_qw    <= '0;
                        r_qh    <= '0;
                        r_undef <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_MOD: begin
                    if (w_sts.done) begin
                        r_y     <= r_x;
                        r_x     <= w_rem;
                        r_state <= S_EUCLID;
                    end
                end
                S_DIVW: begin
                    if (w_sts.done) begin
                        r_qw    <= w_quo;
                        r_state <= S_DIVH;
                    end
                end
                S_DIVH: begin
                    if (w_sts.done) begin
                        r_qh    <= w_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_m_tready) begin
                        r_out_data  <= OUT_W'({r_y, r_qh, r_qw});
                        r_out_user  <= r_undef;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

/* verif/ratio_reduction_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the ratio reducer, predicts each reduced ratio on
// input acceptance and compares it with the next word that leaves the block.
module ratio_reduction_checker #(
    parameter int DIM_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    input  wire logic                                 i_s_tready,
    // width, height
    input  wire logic [((2*DIM_BITS+7)/8)*8-1:0]      i_s_tdata,
    input  wire logic                                 i_m_tvalid,
    input  wire logic                                 i_m_tready,
    // reduced_width, reduced_height, common_divisor
    input  wire logic [((3*DIM_BITS+7)/8)*8-1:0]      i_m_tdata,
    // undefined
    input  wire logic                                 i_m_tuser,
    output int                                        o_error_count,
    output int                                        o_ratios_pending
);

    localparam int PRINT_CAP = 32;

    typedef struct packed {
        logic [DIM_BITS-1:0] reduced_width;
        logic [DIM_BITS-1:0] reduced_height;
        logic [DIM_BITS-1:0] common_divisor;
        logic                undefined;
    } t_ratio;

    t_ratio expected_ratios[$];
    int     words_seen  = 0;
    int     error_count = 0;

    assign o_error_count    = error_count;
    assign o_ratios_pending = expected_ratios.size();

    // Euclid by repeated remainder, then divide both sides by the divisor.
    function automatic t_ratio reduce_ratio(input logic [DIM_BITS-1:0] w,
                                            input logic [DIM_BITS-1:0] h);
        logic [DIM_BITS-1:0] x;
        logic [DIM_BITS-1:0] y;
        logic [DIM_BITS-1:0] keep;
        t_ratio              r;
        x = w;
        y = h;
        while (x != '0) begin
            keep = x;
            x    = y % x;
            y    = keep;
        end
        if (y == '0) begin
            r = '{reduced_width: '0, reduced_height: '0, common_divisor: '0,
                  undefined: 1'b1};
        end else begin
            r = '{reduced_width: w / y, reduced_height: h / y, common_divisor: y,
                  undefined: 1'b0};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] ratio word %0d: %s got %0d, want %0d",
                     $realtime, words_seen, what, got, want);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_ratio want;
        if (i_rst_n) begin
            // compare before queueing: a word leaving now cannot be the one entering
            if (i_m_tvalid && i_m_tready) begin
                if (expected_ratios.size() == 0) begin
                    report_mismatch("unexpected word, queue depth", 0, 0);
                end else begin
                    want = expected_ratios.pop_front();
                    if (i_m_tdata[DIM_BITS-1:0] !== want.reduced_width)
                        report_mismatch("reduced_width", i_m_tdata[DIM_BITS-1:0],
                                        want.reduced_width);
                    if (i_m_tdata[2*DIM_BITS-1:DIM_BITS] !== want.reduced_height)
                        report_mismatch("reduced_height", i_m_tdata[2*DIM_BITS-1:DIM_BITS],
                                        want.reduced_height);
                    if (i_m_tdata[3*DIM_BITS-1:2*DIM_BITS] !== want.common_divisor)
                        report_mismatch("common_divisor",
                                        i_m_tdata[3*DIM_BITS-1:2*DIM_BITS],
                                        want.common_divisor);
                    if (i_m_tuser !== want.undefined)
                        report_mismatch("undefined", i_m_tuser, want.undefined);
                end
                words_seen++;
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_ratios.push_back(reduce_ratio(i_s_tdata[DIM_BITS-1:0],
                                                       i_s_tdata[2*DIM_BITS-1:DIM_BITS]));
            end
        end
    end

endmodule

/* verif/reduce_ratio_by_gcd_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the ratio reducer; all prediction and comparison
// lives in the checker instantiated beside the block.
module reduce_ratio_by_gcd_tb;

    localparam int DIM_BITS     = 16;
    localparam int S_BITS       = ((2*DIM_BITS+7)/8)*8;
    localparam int M_BITS       = ((3*DIM_BITS+7)/8)*8;
    localparam int RANDOM_WORDS = 150;          // per idling phase, four phases
    localparam int DRAIN_CYCLES = 600;          // beyond the worst Euclid latency
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic [S_BITS-1:0] i_s_tdata  = '0;         // width, height
    logic              i_m_tready = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [M_BITS-1:0] o_m_tdata;               // reduced_width, reduced_height, common_divisor
    logic              o_m_tuser;               // undefined

    int error_count;
    int ratios_pending;
    int cycle_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    reduce_ratio_by_gcd #(.DIM_BITS(DIM_BITS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    ratio_reduction_checker #(.DIM_BITS(DIM_BITS)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .o_error_count    (error_count),
        .o_ratios_pending (ratios_pending)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a word.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: one roll per cycle, so stalls land on any phase of the result wait.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Offer one word from a falling edge and hold it until accepted. Valid is
    // left high on return so that a back-to-back word needs no drop in between.
    task automatic push_pair(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_BITS'({h, w});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mix of shapes: plain random, shared factors (so the divisor is not
    // mostly 1), a zero on one side, equal sides, Fibonacci neighbours for long
    // Euclid chains, and tiny values.
    task automatic push_random_pair();
        int          mode;
        int          g;
        int          a;
        int          b;
        int          t;
        int          steps;
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2, 3: begin
                push_pair(DIM_BITS'($urandom), DIM_BITS'($urandom));
            end
            4, 5, 6: begin
                g = $urandom_range(1, 1 << $urandom_range(1, 12));
                a = $urandom_range(0, 65535 / g);
                b = $urandom_range(0, 65535 / g);
                push_pair(DIM_BITS'(g * a), DIM_BITS'(g * b));
            end
            7: begin
                a = $urandom_range(0, 65535);
                if ($urandom_range(1)) push_pair(DIM_BITS'(a), '0);
                else                   push_pair('0, DIM_BITS'(a));
            end
            8: begin
                if ($urandom_range(1)) begin
                    a = $urandom_range(0, 65535);
                    push_pair(DIM_BITS'(a), DIM_BITS'(a));
                end else begin
                    a = 1;
                    b = 1;
                    steps = $urandom_range(1, 22);
                    repeat (steps) begin
                        t = a + b;
                        a = b;
                        b = t;
                    end
                    g = $urandom_range(1, 65535 / b);
                    if ($urandom_range(1)) push_pair(DIM_BITS'(a * g), DIM_BITS'(b * g));
                    else                   push_pair(DIM_BITS'(b * g), DIM_BITS'(a * g));
                end
            end
            default: begin
                push_pair(DIM_BITS'($urandom_range(15)), DIM_BITS'($urandom_range(15)));
            end
        endcase
    endtask

    initial begin
        // hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words, no idling: both zero (undefined), one side zero,
        // extremes, unity, common picture sizes, the longest Euclid chain.
        push_pair('0, '0);
        push_pair('0, 16'd5);
        push_pair(16'd5, '0);
        push_pair('0, DIM_MAX);
        push_pair(DIM_MAX, '0);
        push_pair(DIM_MAX, DIM_MAX);
        push_pair(16'd1, 16'd1);
        push_pair(16'd1, DIM_MAX);
        push_pair(DIM_MAX, 16'd1);
        push_pair(16'd1920, 16'd1080);
        push_pair(16'd1280, 16'd720);
        push_pair(16'd720, 16'd576);
        push_pair(16'd46368, 16'd28657);
        push_pair(16'd28657, 16'd46368);
        push_pair(16'hAAAA, 16'h5555);
        push_pair(16'h8000, 16'h8000);
        push_pair(16'h8000, 16'h4000);
        push_pair(16'd65521, 16'd65519);
        push_pair(16'd12, 16'd18);
        push_pair(16'd7, 16'd7);

        // Random words over four idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 77; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 77; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            repeat (RANDOM_WORDS) push_random_pair();
        end

        // drop valid, let the receiver run free and wait for the queue to empty
        i_s_tvalid <= 1'b0;
        sink_stall_pct = 0;
        while (ratios_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
